// ===== rtl/core/kls_pkg.sv =====
// ----------------------------------------------------------------------------
// kls_pkg
// Shared types and constants of the keyed latency statistics table.
// ----------------------------------------------------------------------------
package kls_pkg;

    localparam int KEY_W   = 16;
    localparam int COUNT_W = 64;
    localparam int TIME_W  = 63;

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_DUMP   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DUMP,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  sum;
        logic [TIME_W-1:0]  minimum;
        logic [TIME_W-1:0]  maximum;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic full;
        logic empty;
    } lookup_t;

endpackage

// ===== rtl/core/keyed_latency_statistics_table.sv =====
// ----------------------------------------------------------------------------
// keyed_latency_statistics_table
// Per-key event count and elapsed-time statistics with dump and clear.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. For a record,
// the key is matched and the slot read in the accept cycle, and the
// updated slot is written back through the single write port of the slot
// memory in the next. A record for a new key on a full table is dropped, and
// a clear or an unused command is done, without leaving idle. A dump of N
// occupied slots streams one result per cycle in allocation order off the
// memory read port; an empty table gives one result with entry_valid low.
// Results come with result_valid for one cycle each and cannot be stalled;
// last_entry marks the final word of a dump. Records and clears produce no
// result, nor does a record for a new key on a full table.
// ----------------------------------------------------------------------------
module keyed_latency_statistics_table #(
    parameter int MAX_KEYS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  command,
    input  logic [kls_pkg::KEY_W-1:0]   event_key,
    input  logic [kls_pkg::TIME_W-1:0]  start_time,
    input  logic [kls_pkg::TIME_W-1:0]  end_time,
    output logic                        result_valid,
    output logic                        entry_valid,
    output logic [kls_pkg::KEY_W-1:0]   entry_key,
    output logic [kls_pkg::COUNT_W-1:0] event_count,
    output logic [kls_pkg::TIME_W-1:0]  total_time,
    output logic [kls_pkg::TIME_W-1:0]  least_time,
    output logic [kls_pkg::TIME_W-1:0]  greatest_time,
    output logic                        last_entry
);

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    kls_pkg::state_t state_reg;
    kls_pkg::state_t state_next;
    kls_pkg::cmd_t   cmd;

    kls_pkg::lookup_t status;
    logic [IDX_W-1:0] hit_idx;
    logic [CNT_W-1:0] used;

    logic accept;
    logic alloc;
    logic clear;
    logic do_update;
    logic dump_last;

    logic [IDX_W-1:0]           raddr;
    kls_pkg::entry_t            rdata;
    kls_pkg::entry_t            new_entry;
    logic [kls_pkg::TIME_W-1:0] elapsed;

    logic [IDX_W-1:0]           addr_reg;
    logic                       fresh_reg;
    logic [kls_pkg::KEY_W-1:0]  key_reg;
    logic [kls_pkg::TIME_W-1:0] elapsed_reg;
    logic [IDX_W-1:0]           dump_idx_reg;
    logic [IDX_W-1:0]           dump_idx_next;

    assign cmd    = kls_pkg::cmd_t'(command);
    assign accept = start && !busy;
    assign alloc  = accept && (cmd == kls_pkg::CMD_RECORD) && !status.hit && !status.full;
    assign clear  = accept && (cmd == kls_pkg::CMD_CLEAR);
    assign do_update = (state_reg == kls_pkg::ST_UPDATE);
    assign dump_last = ((CNT_W'(dump_idx_reg) + CNT_W'(1)) == used);
    assign elapsed   = (end_time > start_time) ? (end_time - start_time) : '0;

    kls_key_cam #(
        .MAX_KEYS (MAX_KEYS),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (event_key),
        .alloc      (alloc),
        .clear      (clear),
        .status     (status),
        .hit_idx    (hit_idx),
        .used       (used)
    );

    kls_stat_ram #(
        .DEPTH  (MAX_KEYS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (do_update),
        .waddr (addr_reg),
        .wdata (new_entry),
        .raddr (raddr),
        .rdata (rdata)
    );

    kls_update_alu u_alu (
        .old_entry (rdata),
        .fresh     (fresh_reg),
        .key       (key_reg),
        .elapsed   (elapsed_reg),
        .new_entry (new_entry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kls_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        kls_pkg::CMD_RECORD:
                        begin
                            if (status.hit || !status.full)
                            begin
                                state_next = kls_pkg::ST_UPDATE;
                            end
                        end
                        kls_pkg::CMD_DUMP:
                        begin
                            state_next = status.empty ? kls_pkg::ST_EMPTY
                                                      : kls_pkg::ST_DUMP;
                        end
                        default:
                        begin
                            state_next = kls_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            kls_pkg::ST_UPDATE:
            begin
                state_next = kls_pkg::ST_IDLE;
            end
            kls_pkg::ST_DUMP:
            begin
                if (dump_last)
                begin
                    state_next = kls_pkg::ST_IDLE;
                end
            end
            kls_pkg::ST_EMPTY:
            begin
                state_next = kls_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and read address
    always_comb
    begin
        busy          = 1'b1;
        raddr         = hit_idx;
        dump_idx_next = dump_idx_reg;
        result_valid  = 1'b0;
        entry_valid   = 1'b0;
        entry_key     = '0;
        event_count   = '0;
        total_time    = '0;
        least_time    = '0;
        greatest_time = '0;
        last_entry    = 1'b0;
        unique case (state_reg)
            kls_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (cmd == kls_pkg::CMD_DUMP)
                begin
                    raddr         = '0;
                    dump_idx_next = '0;
                end
            end
            kls_pkg::ST_UPDATE:
            begin
                raddr = addr_reg;
            end
            kls_pkg::ST_DUMP:
            begin
                raddr         = dump_idx_reg + IDX_W'(1);
                dump_idx_next = dump_idx_reg + IDX_W'(1);
                result_valid  = 1'b1;
                entry_valid   = 1'b1;
                entry_key     = rdata.key;
                event_count   = rdata.count;
                total_time    = rdata.sum;
                least_time    = rdata.minimum;
                greatest_time = rdata.maximum;
                last_entry    = dump_last;
            end
            kls_pkg::ST_EMPTY:
            begin
                result_valid = 1'b1;
                last_entry   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kls_pkg::ST_IDLE;
            dump_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            dump_idx_reg <= dump_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg    <= status.hit ? hit_idx : used[IDX_W-1:0];
            fresh_reg   <= !status.hit;
            key_reg     <= event_key;
            elapsed_reg <= elapsed;
        end
    end

endmodule

// ===== rtl/core/kls_key_cam.sv =====
// ----------------------------------------------------------------------------
// kls_key_cam
// Key registers of the occupied slots with a parallel match and the slot count.
// ----------------------------------------------------------------------------
module kls_key_cam #(
    parameter int MAX_KEYS = 32,
    parameter int IDX_W    = 5,
    parameter int CNT_W    = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [kls_pkg::KEY_W-1:0] lookup_key,
    input  logic                     alloc,
    input  logic                     clear,
    output kls_pkg::lookup_t         status,
    output logic [IDX_W-1:0]         hit_idx,
    output logic [CNT_W-1:0]         used
);

    logic [kls_pkg::KEY_W-1:0] key_reg [MAX_KEYS];
    logic [CNT_W-1:0]          used_reg;
    logic [CNT_W-1:0]          used_next;
    logic [MAX_KEYS-1:0]       match;

    always_comb
    begin
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            match[i] = (CNT_W'(i) < used_reg) && (key_reg[i] == lookup_key);
        end
    end

    // keys are unique among occupied slots, so an OR encode is exact
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            if (match[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign status.hit   = |match;
    assign status.full  = (used_reg == CNT_W'(MAX_KEYS));
    assign status.empty = (used_reg == '0);
    assign used         = used_reg;

    always_comb
    begin
        priority if (clear)
        begin
            used_next = '0;
        end
        else if (alloc)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        else
        begin
            used_next = used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            key_reg[used_reg[IDX_W-1:0]] <= lookup_key;
        end
    end

endmodule

// ===== rtl/core/kls_stat_ram.sv =====
// ----------------------------------------------------------------------------
// kls_stat_ram
// Slot statistics memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module kls_stat_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  kls_pkg::entry_t   wdata,
    input  logic [ADDR_W-1:0] raddr,
    output kls_pkg::entry_t   rdata
);

    kls_pkg::entry_t mem [DEPTH];
    kls_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/kls_update_alu.sv =====
// ----------------------------------------------------------------------------
// kls_update_alu
// Folds one elapsed time into a slot: count, saturating sum, min and max.
// ----------------------------------------------------------------------------
module kls_update_alu (
    input  kls_pkg::entry_t            old_entry,
    input  logic                       fresh,
    input  logic [kls_pkg::KEY_W-1:0]  key,
    input  logic [kls_pkg::TIME_W-1:0] elapsed,
    output kls_pkg::entry_t            new_entry
);

    logic [kls_pkg::COUNT_W-1:0] count0;
    logic [kls_pkg::TIME_W-1:0]  sum0;
    logic [kls_pkg::TIME_W-1:0]  min0;
    logic [kls_pkg::TIME_W-1:0]  max0;
    logic [kls_pkg::TIME_W:0]    sum_wide;

    // a freshly allocated slot starts from zero
    assign count0   = fresh ? '0 : old_entry.count;
    assign sum0     = fresh ? '0 : old_entry.sum;
    assign min0     = fresh ? '0 : old_entry.minimum;
    assign max0     = fresh ? '0 : old_entry.maximum;
    assign sum_wide = {1'b0, sum0} + {1'b0, elapsed};

    always_comb
    begin
        new_entry.key     = key;
        new_entry.count   = (count0 == kls_pkg::COUNT_MAX) ? count0
                            : count0 + kls_pkg::COUNT_W'(1);
        new_entry.sum     = sum_wide[kls_pkg::TIME_W] ? kls_pkg::TIME_MAX
                            : sum_wide[kls_pkg::TIME_W-1:0];
        new_entry.minimum = ((count0 == '0) || (elapsed < min0)) ? elapsed : min0;
        new_entry.maximum = (elapsed > max0) ? elapsed : max0;
    end

endmodule
